>>> hdl/afdp_pkg.sv
// ----------------------------------------------------------------------------
// afdp_pkg - shared types and constants of the framed decimal packet parser
// Holds the frame markers, the raw frame record passed from the front
// part to the back part, and the ASCII digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package afdp_pkg;

  // frame markers and character codes
  localparam logic [7:0] MarkByte   = 8'h40;  // '@'
  localparam logic [7:0] ZeroChar   = 8'd48;  // '0'
  localparam logic [7:0] KindTarget = 8'h53;  // 'S'

  // payload layout: kind byte then eleven digit bytes
  localparam int PayloadLen = 12;
  localparam int DigitCount = PayloadLen - 1;
  localparam int CountW     = $clog2(PayloadLen + 1);

  // target registers after reset
  localparam logic [9:0] TargetReset = 10'd123;

  // frame phase codes
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhCollect = 2'd1;
  localparam logic [1:0] PhClose   = 2'd2;

  typedef logic [CountW-1:0] count_t;

  // one complete frame as stored between front and back
  typedef struct packed {
    logic [DigitCount-1:0][7:0] digit_bytes;  // payload bytes 1..11
    logic [7:0]                 kind;         // payload byte 0
  } frame_t;

  // handshake of the frame queue towards the back part
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_req_t;

  // true when the byte is an ASCII decimal digit
  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ZeroChar) && (b <= ZeroChar + 8'd9);
  endfunction

  // digit value, zero for a non-digit byte
  function automatic logic [3:0] digit_value(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - ZeroChar;
    return is_digit(b) ? diff[3:0] : 4'd0;
  endfunction

endpackage

`default_nettype wire

>>> hdl/at_framed_decimal_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// at_framed_decimal_packet_parser_unit - framed decimal packet parser
// Parses '@' + 12 payload bytes + '@' + '@' frames into kind and numbers.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle. A byte travels on the
// slave stream in tdata with hold_off in tuser. The final '@' of a frame
// moves the frame into a two-entry queue; the decoder loads the result
// register from the queue head once that register is empty or drained.
// The input stalls while both queue entries hold frames, which only happens
// when the downstream side holds off for longer than a frame, since frames
// are at least fifteen bytes long; at full output rate the input never stalls.
// Results carry kind and digit_error in tuser and the numbers in tdata.
`default_nettype none

module at_framed_decimal_packet_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  input  wire logic        s_axis_tuser,   // hold_off
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // dist_x, dist_y, size_value,
                                           // target_x, target_y, zero fill
  output logic [8:0]       m_axis_tuser    // kind, digit_error
);

  logic                  accept;
  logic                  push;
  logic                  full;
  logic                  pop;
  afdp_pkg::frame_t      frame;
  afdp_pkg::frame_req_t  head;

  // input transfer when the queue has room
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  afdp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (s_axis_tdata),
    .hold_off_i (s_axis_tuser),
    .frame_o    (frame),
    .push_o     (push)
  );

  afdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (frame),
    .full_o  (full),
    .head_o  (head),
    .pop_i   (pop)
  );

  afdp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> hdl/afdp_front.sv
// ----------------------------------------------------------------------------
// afdp_front - frame tracker
// Accepts one byte per cycle while accept_i is high, follows the start / payload / close phases,
// stores the twelve payload bytes and pushes a complete frame on the
// closing marker.
// ----------------------------------------------------------------------------
`default_nettype none

module afdp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,   // byte transfer this cycle
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            hold_off_i,
  output afdp_pkg::frame_t     frame_o,
  output logic                 push_o
);

  logic [1:0]        phase_q, phase_d;
  afdp_pkg::count_t  count_q, count_d;
  logic [7:0]        store_q [afdp_pkg::PayloadLen];
  logic              is_mark;
  logic              store_we;

  assign is_mark = (rx_byte_i == afdp_pkg::MarkByte);

  // phase and byte count update
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    store_we = 1'b0;
    push_o   = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        afdp_pkg::PhCollect: begin
          if (count_q == afdp_pkg::count_t'(afdp_pkg::PayloadLen)) begin
            // payload full: marker closes, anything else drops the frame
            phase_d = is_mark ? afdp_pkg::PhClose : afdp_pkg::PhIdle;
            count_d = is_mark ? count_q : '0;
          end else begin
            store_we = 1'b1;
            count_d  = count_q + afdp_pkg::count_t'(1);
          end
        end
        afdp_pkg::PhClose: begin
          // noise ignored until the final marker
          if (is_mark) begin
            push_o  = 1'b1;
            phase_d = afdp_pkg::PhIdle;
            count_d = '0;
          end
        end
        default: begin
          phase_d = afdp_pkg::PhIdle;
          if (is_mark && !hold_off_i) begin
            phase_d = afdp_pkg::PhCollect;
            count_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= afdp_pkg::PhIdle;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // payload store, no reset
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= rx_byte_i;
    end
  end

  // frame record from the store
  always_comb begin
    frame_o.kind = store_q[0];
    for (int i = 0; i < afdp_pkg::DigitCount; i++) begin
      frame_o.digit_bytes[i] = store_q[i+1];
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= afdp_pkg::count_t'(afdp_pkg::PayloadLen))
    else $error("byte count past payload length");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (count_q == afdp_pkg::count_t'(afdp_pkg::PayloadLen)))
    else $error("frame pushed with incomplete payload");

endmodule

`default_nettype wire

>>> hdl/afdp_queue.sv
// ----------------------------------------------------------------------------
// afdp_queue - two-entry frame queue
// Decouples the frame tracker from the decoder so that either side may
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module afdp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire afdp_pkg::frame_t frame_i,
  output logic                  full_o,
  output afdp_pkg::frame_req_t  head_o,
  input  wire logic             pop_i
);

  afdp_pkg::frame_t entry_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o         = (fill_q == 2'd2);
  assign head_o.valid   = (fill_q != 2'd0);
  assign head_o.frame   = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= frame_i;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("frame queue underflow");

endmodule

`default_nettype wire

>>> hdl/afdp_back.sv
// ----------------------------------------------------------------------------
// afdp_back - frame decoder
// Converts the queued frame's decimal digits, updates the target registers
// on a valid 'S' frame and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module afdp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire afdp_pkg::frame_req_t head_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // dist_x, dist_y, size_value,
                                                   // target_x, target_y, zero fill
  output logic [8:0]                m_axis_tuser   // kind, digit_error
);

  logic [3:0]  dig [afdp_pkg::DigitCount];
  logic        all_ok;
  logic [9:0]  x_val, y_val;
  logic [16:0] s_val;
  logic [9:0]  tx_q, ty_q, tx_d, ty_d;
  logic        valid_q;
  logic [7:0]  kind_q;
  logic        err_q;
  logic [9:0]  x_q, y_q;
  logic [16:0] s_q;

  // digit extraction and check
  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < afdp_pkg::DigitCount; i++) begin
      dig[i] = afdp_pkg::digit_value(head_i.frame.digit_bytes[i]);
      all_ok = all_ok & afdp_pkg::is_digit(head_i.frame.digit_bytes[i]);
    end
  end

  // constant-weight decimal conversion
  assign x_val = 10'(dig[0]) * 10'd100 + 10'(dig[1]) * 10'd10 + 10'(dig[2]);
  assign y_val = 10'(dig[3]) * 10'd100 + 10'(dig[4]) * 10'd10 + 10'(dig[5]);
  assign s_val = 17'(dig[6]) * 17'd10000 + 17'(dig[7]) * 17'd1000
               + 17'(dig[8]) * 17'd100 + 17'(dig[9]) * 17'd10 + 17'(dig[10]);

  // load the output register when empty or drained
  assign pop_o = head_i.valid && (!valid_q || m_axis_tready);

  // target update on a clean 'S' frame
  always_comb begin
    tx_d = tx_q;
    ty_d = ty_q;
    if (pop_o && all_ok && (head_i.frame.kind == afdp_pkg::KindTarget)) begin
      tx_d = x_val;
      ty_d = y_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tx_q    <= afdp_pkg::TargetReset;
      ty_q    <= afdp_pkg::TargetReset;
    end else begin
      tx_q <= tx_d;
      ty_q <= ty_d;
      if (pop_o) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= head_i.frame.kind;
      err_q  <= !all_ok;
      x_q    <= all_ok ? x_val : '0;
      y_q    <= all_ok ? y_val : '0;
      s_q    <= all_ok ? s_val : '0;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {7'd0, ty_q, tx_q, s_q, y_q, x_q};
  assign m_axis_tuser  = {err_q, kind_q};

  // checks
  a_target_moves_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !($stable(tx_q) && $stable(ty_q)) |-> $past(pop_o))
    else $error("target registers changed without a frame");

  a_valid_rise_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(pop_o))
    else $error("result raised without a frame");

endmodule

`default_nettype wire
